>>> sv/rcat_pkg.sv
// ----------------------------------------------------------------------------
// Remote code action table package
// Shared constants, transaction types and sequencer states.
// ----------------------------------------------------------------------------
package rcat_pkg;

  localparam int ACTIONS          = 7;
  localparam int SLOTS_PER_ACTION = 4;
  localparam int DEPTH            = (ACTIONS - 1) * SLOTS_PER_ACTION;
  localparam int IDX_W            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W           = (SLOTS_PER_ACTION > 1) ? $clog2(SLOTS_PER_ACTION) : 1;
  localparam int ACT_W            = 3;
  localparam int CODE_W           = 32;
  localparam int MASK_W           = 8;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_ARG = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CODE_W-1:0] code;
    logic [ACT_W-1:0]  dest_action;
  } rcat_in_t;

  typedef struct packed {
    logic              status;
    logic [ACT_W-1:0]  found_action;
    logic [MASK_W-1:0] changed_mask;
  } rcat_out_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [CODE_W-1:0] data;
  } rcat_wr_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CLEAR,
    SEQ_SCAN,
    SEQ_FIND,
    SEQ_SHIFT,
    SEQ_DONE
  } rcat_seq_t;

endpackage

>>> sv/rcat_slots.sv
// ----------------------------------------------------------------------------
// Remote code action table slot store
// Slot registers with one write port and one read address, cleared at reset.
// ----------------------------------------------------------------------------
module rcat_slots
  import rcat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rcat_wr_t          wr,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [CODE_W-1:0] rd_data
);

  logic [CODE_W-1:0] slot_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_r[i] <= '0;
      end
    end else if (wr.en) begin
      slot_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = slot_r[rd_addr];

endmodule

>>> sv/remote_code_action_table.sv
// ----------------------------------------------------------------------------
// Remote code action table
// Maps remote-control codes to action numbers with add, remove and lookup.
// ----------------------------------------------------------------------------
// Channel  Ports                          Direction  Payload
// in       in_valid, in_stall, in_data    input      operation, code, dest
// out      out_valid, out_stall, out_data output     status, found, mask
//
// One transaction at a time; a single read address walks the slots one per cycle.
// Add clears matching slots, then fills a free slot of dest_action or shifts its
// group; remove clears matches; lookup stops at a match; bad requests skip to done.
// Synchronous reset empties every slot.
// A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module remote_code_action_table
  import rcat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rcat_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rcat_out_t out_data
);

  rcat_seq_t         st_r, st_nxt;
  rcat_in_t          req_r, req_nxt;
  rcat_out_t         res_r, res_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  rcat_wr_t          wr;
  logic [IDX_W-1:0]  rd_addr;
  logic [CODE_W-1:0] rd_data;
  logic [IDX_W-1:0]  base_idx;
  logic              match;
  logic              empty;
  logic              scan_last;
  logic              slot_last;
  logic              bad_req;

  rcat_slots u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign match     = (rd_data == req_r.code);
  assign empty     = (rd_data == '0);
  assign scan_last = (idx_r == IDX_W'(DEPTH - 1));
  assign slot_last = (slot_r == SLOT_W'(SLOTS_PER_ACTION - 1));
  assign base_idx  = IDX_W'((int'(req_r.dest_action) - 1) * SLOTS_PER_ACTION);

  assign bad_req = (in_data.operation != OP_ADD && in_data.operation != OP_REMOVE &&
                    in_data.operation != OP_LOOKUP) ||
                   (in_data.code == '0) ||
                   (in_data.operation == OP_ADD &&
                    (in_data.dest_action == '0 ||
                     {1'b0, in_data.dest_action} >= (ACT_W + 1)'(ACTIONS)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SEQ_IDLE;
      idx_r  <= '0;
      slot_r <= '0;
      act_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      slot_r <= slot_nxt;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    act_nxt   = act_r;
    wr        = '0;
    rd_addr   = idx_r;
    in_stall  = (st_r != SEQ_IDLE);
    out_valid = (st_r == SEQ_DONE);

    unique case (st_r) inside
      SEQ_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          res_nxt  = '0;
          idx_nxt  = '0;
          slot_nxt = '0;
          act_nxt  = ACT_W'(1);
          if (bad_req) begin
            res_nxt.status = ST_BAD_ARG;
            st_nxt         = SEQ_DONE;
          end else if (in_data.operation == OP_LOOKUP) begin
            st_nxt = SEQ_SCAN;
          end else begin
            st_nxt = SEQ_CLEAR;
          end
        end
      end
      SEQ_CLEAR, SEQ_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (slot_last) begin
          slot_nxt = '0;
          act_nxt  = act_r + ACT_W'(1);
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        if (st_r == SEQ_CLEAR) begin
          if (match) begin
            wr.en   = 1'b1;
            wr.addr = idx_r;
            wr.data = '0;
            res_nxt.changed_mask = res_nxt.changed_mask | (MASK_W'(1) << act_r);
          end
          if (scan_last) begin
            if (req_r.operation == OP_ADD) begin
              res_nxt.changed_mask = res_nxt.changed_mask |
                                     (MASK_W'(1) << req_r.dest_action);
              idx_nxt  = base_idx;
              slot_nxt = '0;
              st_nxt   = SEQ_FIND;
            end else begin
              st_nxt = SEQ_DONE;
            end
          end
        end else begin
          if (match) begin
            res_nxt.found_action = act_r;
            st_nxt               = SEQ_DONE;
          end else if (scan_last) begin
            st_nxt = SEQ_DONE;
          end
        end
      end
      SEQ_FIND: begin
        if (empty) begin
          wr.en   = 1'b1;
          wr.addr = idx_r;
          wr.data = req_r.code;
          st_nxt  = SEQ_DONE;
        end else if (slot_last) begin
          idx_nxt  = base_idx;
          slot_nxt = '0;
          st_nxt   = SEQ_SHIFT;
        end else begin
          idx_nxt  = idx_r + IDX_W'(1);
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      SEQ_SHIFT: begin
        wr.en   = 1'b1;
        wr.addr = idx_r;
        if (slot_last) begin
          wr.data = req_r.code;
          st_nxt  = SEQ_DONE;
        end else begin
          rd_addr  = idx_r + IDX_W'(1);
          wr.data  = rd_data;
          idx_nxt  = idx_r + IDX_W'(1);
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      SEQ_DONE: begin
        if (!out_stall) begin
          st_nxt = SEQ_IDLE;
        end
      end
      default: begin
        st_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign out_data = res_r;

endmodule
